// ===== sv/multi_client_watchdog_defines.svh =====
// Assertion macros used by the watchdog top level.
`ifndef MULTI_CLIENT_WATCHDOG_DEFINES_SVH
`define MULTI_CLIENT_WATCHDOG_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define MCW_AST_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masks the check.
`define MCW_AST_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mcw_pkg.sv =====
// Package: sizes, codes and record types of the multi-client watchdog.
`default_nettype none
package mcw_pkg;

    localparam int unsigned CLIENTS = 16;

    localparam int unsigned SLOT_W = 4;
    localparam int unsigned TIME_W = 48;
    localparam int unsigned INTV_W = 40;
    localparam int unsigned MST_W  = 3;
    localparam int unsigned MODE_W = 3;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned REP_W  = 2;
    localparam int unsigned CIDX_W = 2;
    localparam int unsigned CFG_W  = INTV_W;

    localparam int unsigned AW    = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int unsigned IDX_W = $clog2(CLIENTS + 1);

    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REG   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PING  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_UNREG = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SETST = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_BADPAR = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DUP    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOREG  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL   = 3'd4;

    localparam logic [REP_W-1:0] REP_PING = 2'd1;
    localparam logic [REP_W-1:0] REP_ALL  = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_ENABLE   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_CRASH    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MIN_INTV = 2'd2;

    localparam logic [INTV_W-1:0] MIN_INTV_RST = 40'd500000;

    // One client slot as held in the state memory.
    typedef struct packed {
        logic [MST_W-1:0]  mon_state;
        logic [INTV_W-1:0] interval;
        logic [INTV_W-1:0] wait_us;
        logic [TIME_W-1:0] reg_at;
        logic [TIME_W-1:0] last_upd;
    } t_rec;

    localparam int unsigned REC_W = $bits(t_rec);

    // Verdict of the check unit for one slot.
    typedef struct packed {
        logic              stale;
        logic              hit;
        logic [TIME_W-1:0] od_new;
        logic [TIME_W-1:0] od_rep;
    } t_chk;

endpackage
`default_nettype wire

// ===== sv/mcw_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
`default_nettype none
module mcw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== sv/mcw_check.sv =====
// Check unit: registered overdue and stale verdict for one slot record.
`default_nettype none
module mcw_check import mcw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  t_rec             i_rec,
    input  logic [TIME_W-1:0] i_now,
    input  logic [MST_W-1:0] i_app_state,
    output t_chk             o_chk
);

    localparam int unsigned D_W = TIME_W + 2;

    logic [D_W-1:0] diff_upd;
    logic [D_W-1:0] diff_reg;
    logic           hit_upd;
    logic           hit_reg;
    t_chk           r_chk;

    // Signed margins: elapsed minus limit, positive means past the limit.
    assign diff_upd = D_W'(i_now) - D_W'(i_rec.last_upd) - D_W'(i_rec.interval);
    assign diff_reg = D_W'(i_now) - D_W'(i_rec.reg_at) - D_W'(i_rec.wait_us);
    assign hit_upd  = !diff_upd[D_W-1] && (diff_upd != '0);
    assign hit_reg  = !diff_reg[D_W-1] && (diff_reg != '0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chk.stale  <= (i_app_state > i_rec.mon_state);
            r_chk.hit    <= hit_upd && hit_reg;
            r_chk.od_new <= diff_upd[TIME_W-1:0];
            r_chk.od_rep <= i_now - i_rec.last_upd;
        end
    end

    assign o_chk = r_chk;

endmodule
`default_nettype wire

// ===== sv/multi_client_watchdog.sv =====
// Top level: multi-client watchdog with slot table in a synchronous RAM.
// Non-tick results are loaded in ST_DEC (a ping's in ST_PWB, after its record read),
// each waiting while the output register is full; the sequencer holds one item and
// takes no new input beat until it is back in ST_IDLE. A tick holds the input for
// the per-slot read, check and write-back on the single RAM port pair.
// Reset: synchronous, active low; clears control, valid/flag bits and config; RAM not cleared.
`default_nettype none
`include "multi_client_watchdog_defines.svh"
module multi_client_watchdog import mcw_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write port
    input  logic                     i_cfg_we,
    input  logic [CIDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_wdata,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic [SLOT_W-1:0]        i_slot,
    input  logic [TIME_W-1:0]        i_now_us,
    input  logic [MST_W-1:0]         i_client_state,
    input  logic [INTV_W-1:0]        i_interval_us,
    input  logic signed [INTV_W-1:0] i_wait_us,
    input  logic [REP_W-1:0]         i_replace_mode,
    input  logic [MST_W-1:0]         i_app_state,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [SLOT_W-1:0]        o_out_slot,
    output logic                     o_violation,
    output logic                     o_is_new,
    output logic [TIME_W-1:0]        o_overdue_us,
    output logic [STAT_W-1:0]        o_status,
    output logic                     o_crash,
    output logic                     o_last
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;  // wait for an input beat
    localparam logic [2:0] ST_DEC  = 3'd1;  // decode and apply the operation
    localparam logic [2:0] ST_PWB  = 3'd2;  // ping: write back refreshed record
    localparam logic [2:0] ST_TRD  = 3'd3;  // tick: pick next slot, issue read
    localparam logic [2:0] ST_TEV  = 3'd4;  // tick: check unit evaluates record
    localparam logic [2:0] ST_TWB  = 3'd5;  // tick: write back, emit flag beat
    localparam logic [2:0] ST_SUM  = 3'd6;  // tick: emit summary beat

    logic [2:0]         r_state, n_state;

    // configuration
    logic               r_enable;
    logic               r_crash_en;
    logic [INTV_W-1:0]  r_min_intv;

    // control state held in flops
    logic [CLIENTS-1:0] r_valid, n_valid;
    logic [CLIENTS-1:0] r_flag,  n_flag;
    logic [MST_W-1:0]   r_app,   n_app;
    logic [IDX_W-1:0]   r_idx,   n_idx;
    logic               r_any,   n_any;

    // captured item
    logic [MODE_W-1:0]  r_mode;
    logic [SLOT_W-1:0]  r_slot;
    logic [TIME_W-1:0]  r_now;
    logic [MST_W-1:0]   r_cstate;
    logic [INTV_W-1:0]  r_intv;
    logic [INTV_W-1:0]  r_wait;
    logic [REP_W-1:0]   r_rep;
    logic [MST_W-1:0]   r_appst;

    // output register
    logic               r_ov;
    logic [SLOT_W-1:0]  r_o_slot;
    logic               r_o_viol;
    logic               r_o_new;
    logic [TIME_W-1:0]  r_o_od;
    logic [STAT_W-1:0]  r_o_stat;
    logic               r_o_crash;
    logic               r_o_last;

    // beat to load
    logic               ld;
    logic [SLOT_W-1:0]  e_slot;
    logic               e_viol;
    logic               e_new;
    logic [TIME_W-1:0]  e_od;
    logic [STAT_W-1:0]  e_stat;
    logic               e_crash;
    logic               e_last;

    // RAM and check unit
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    t_rec               ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [REC_W-1:0]   ram_rdata;
    t_rec               rd_rec;
    t_rec               new_rec;
    logic               chk_en;
    t_chk               chk;

    // decode helpers
    logic [AW-1:0]      s_addr;
    logic [AW-1:0]      t_addr;
    logic               slot_ok;
    logic               s_valid;
    logic               params_bad;
    logic               tick_done;
    logic               out_free;
    logic               ping_path;

    assign rd_rec     = t_rec'(ram_rdata);
    assign s_addr     = AW'(r_slot);
    assign t_addr     = r_idx[AW-1:0];
    assign slot_ok    = (32'(r_slot) < CLIENTS);
    assign s_valid    = slot_ok && r_valid[s_addr];
    assign params_bad = (r_intv < r_min_intv) || r_wait[INTV_W-1];
    assign tick_done  = (r_idx == IDX_W'(CLIENTS));
    assign out_free   = !r_ov || i_out_ready;
    // a ping, or a register that degrades to a ping, needs a read-modify-write
    assign ping_path  = r_enable && s_valid &&
                        ((r_mode == MODE_PING) || ((r_mode == MODE_REG) && (r_rep == REP_PING)));

    assign o_in_ready = (r_state == ST_IDLE);

    // Fresh record for a new registration
    assign new_rec.mon_state = r_cstate;
    assign new_rec.interval  = r_intv;
    assign new_rec.wait_us   = r_wait;
    assign new_rec.reg_at    = r_now;
    assign new_rec.last_upd  = r_now;

    always_comb begin
        n_state   = r_state;
        n_valid   = r_valid;
        n_flag    = r_flag;
        n_app     = r_app;
        n_idx     = r_idx;
        n_any     = r_any;
        ld        = 1'b0;
        e_slot    = '0;
        e_viol    = 1'b0;
        e_new     = 1'b0;
        e_od      = '0;
        e_stat    = STAT_OK;
        e_crash   = 1'b0;
        e_last    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = s_addr;
        ram_wdata = new_rec;
        ram_re    = 1'b0;
        ram_raddr = s_addr;
        chk_en    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DEC;
                end
            end

            ST_DEC: begin
                if (r_mode == MODE_TICK) begin
                    n_any   = 1'b0;
                    n_idx   = '0;
                    n_state = r_enable ? ST_TRD : ST_SUM;
                end else if (ping_path) begin
                    // fetch the record so that the registration time survives
                    ram_re  = 1'b1;
                    n_state = ST_PWB;
                end else if (out_free) begin
                    ld      = 1'b1;
                    e_last  = 1'b1;
                    e_slot  = (r_mode inside {MODE_REG, MODE_PING, MODE_UNREG}) ? r_slot : '0;
                    n_state = ST_IDLE;
                    if (r_enable) begin
                        case (r_mode)
                            MODE_REG: begin
                                if (!slot_ok) begin
                                    e_stat = STAT_FULL;
                                end else begin
                                    // replace all frees the slot before the checks
                                    if (s_valid && (r_rep == REP_ALL)) begin
                                        n_valid[s_addr] = 1'b0;
                                    end
                                    if (params_bad) begin
                                        e_stat = STAT_BADPAR;
                                    end else if (s_valid && (r_rep != REP_ALL)) begin
                                        e_stat = STAT_DUP;
                                    end else begin
                                        ram_we          = 1'b1;
                                        n_valid[s_addr] = 1'b1;
                                        n_flag[s_addr]  = 1'b0;
                                    end
                                end
                            end
                            MODE_PING: begin
                                e_stat = STAT_NOREG;
                            end
                            MODE_UNREG: begin
                                if (s_valid) begin
                                    n_valid[s_addr] = 1'b0;
                                    n_flag[s_addr]  = 1'b0;
                                end else begin
                                    e_stat = STAT_NOREG;
                                end
                            end
                            MODE_SETST: begin
                                n_app = r_appst;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end

            ST_PWB: begin
                if (out_free) begin
                    ld                 = 1'b1;
                    e_slot             = r_slot;
                    e_last             = 1'b1;
                    ram_we             = 1'b1;
                    ram_wdata          = rd_rec;
                    ram_wdata.last_upd = r_now;
                    n_flag[s_addr]     = 1'b0;
                    n_state            = ST_IDLE;
                end
            end

            ST_TRD: begin
                ram_raddr = t_addr;
                if (tick_done) begin
                    n_state = ST_SUM;
                end else if (!r_valid[t_addr]) begin
                    n_idx = r_idx + IDX_W'(1);
                end else begin
                    ram_re  = 1'b1;
                    n_state = ST_TEV;
                end
            end

            ST_TEV: begin
                chk_en  = 1'b1;
                n_state = ST_TWB;
            end

            ST_TWB: begin
                ram_waddr = t_addr;
                ram_wdata = rd_rec;
                if (chk.stale) begin
                    // client not monitored in this state: restart its clocks
                    ram_we             = 1'b1;
                    ram_wdata.reg_at   = r_now;
                    ram_wdata.last_upd = r_now;
                    n_idx              = r_idx + IDX_W'(1);
                    n_state            = ST_TRD;
                end else if (chk.hit) begin
                    if (out_free) begin
                        ld                 = 1'b1;
                        e_slot             = SLOT_W'(t_addr);
                        e_viol             = 1'b1;
                        e_new              = !r_flag[t_addr];
                        e_od               = r_flag[t_addr] ? chk.od_rep : chk.od_new;
                        ram_we             = 1'b1;
                        ram_wdata.last_upd = r_now;
                        n_flag[t_addr]     = 1'b1;
                        n_any              = 1'b1;
                        n_idx              = r_idx + IDX_W'(1);
                        n_state            = ST_TRD;
                    end
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = ST_TRD;
                end
            end

            ST_SUM: begin
                if (out_free) begin
                    ld      = 1'b1;
                    e_viol  = r_any;
                    e_crash = r_any && r_crash_en;
                    e_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_flag  <= '0;
            r_app   <= '0;
            r_idx   <= '0;
            r_any   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_flag  <= n_flag;
            r_app   <= n_app;
            r_idx   <= n_idx;
            r_any   <= n_any;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b1;
            r_crash_en <= 1'b0;
            r_min_intv <= MIN_INTV_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:   r_enable   <= i_cfg_wdata[0];
                CFG_CRASH:    r_crash_en <= i_cfg_wdata[0];
                CFG_MIN_INTV: r_min_intv <= i_cfg_wdata[INTV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Capture the item on its input beat
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_mode   <= i_mode;
            r_slot   <= i_slot;
            r_now    <= i_now_us;
            r_cstate <= i_client_state;
            r_intv   <= i_interval_us;
            r_wait   <= $unsigned(i_wait_us);
            r_rep    <= i_replace_mode;
            r_appst  <= i_app_state;
        end
    end

    // Output register: drop valid once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (ld) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_o_slot  <= e_slot;
            r_o_viol  <= e_viol;
            r_o_new   <= e_new;
            r_o_od    <= e_od;
            r_o_stat  <= e_stat;
            r_o_crash <= e_crash;
            r_o_last  <= e_last;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_out_slot   = r_o_slot;
    assign o_violation  = r_o_viol;
    assign o_is_new     = r_o_new;
    assign o_overdue_us = r_o_od;
    assign o_status     = r_o_stat;
    assign o_crash      = r_o_crash;
    assign o_last       = r_o_last;

    mcw_ram #(
        .WIDTH (REC_W),
        .DEPTH (CLIENTS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mcw_check u_check (
        .i_clk       (i_clk),
        .i_en        (chk_en),
        .i_rec       (rd_rec),
        .i_now       (r_now),
        .i_app_state (r_app),
        .o_chk       (chk)
    );

    // Assertions
    `MCW_AST_NXT(a_beat_to_decode, i_clk, i_rst_n, i_in_valid && o_in_ready,
                 r_state == ST_DEC, "input beat did not start decode")
    `MCW_AST_IMP(a_partial_is_flag, i_clk, i_rst_n, o_out_valid && !o_last,
                 o_violation && !o_crash && (o_status == STAT_OK),
                 "non-final beat is not a flag report")
    `MCW_AST_IMP(a_ram_write_state, i_clk, i_rst_n, ram_we,
                 (r_state == ST_DEC) || (r_state == ST_PWB) || (r_state == ST_TWB),
                 "RAM written outside a write-back state")
    `MCW_AST_IMP(a_walk_bound, i_clk, i_rst_n, r_state == ST_TWB, !tick_done,
                 "tick write-back past the last slot")

endmodule
`default_nettype wire
